>>> rtl/sboic_pkg.sv
// Shared types, constants and the microcode table of the subtract-and-branch CPU.
`default_nettype none

package sboic_pkg;

  localparam int DEF_MEM_DEPTH = 65536;

  // Port addresses at the top of the 64-bit address space.
  localparam logic [63:0] PORT_BASE  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] PORT_EXIT  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] PORT_PRINT = 64'hFFFF_FFFF_FFFF_FFFE;
  localparam logic [63:0] PORT_STDIN = 64'hFFFF_FFFF_FFFF_FFFD;
  localparam logic [63:0] PORT_FREQ  = 64'hFFFF_FFFF_FFFF_FFFC;
  localparam logic [63:0] PORT_TIME  = 64'hFFFF_FFFF_FFFF_FFFB;
  localparam logic [63:0] PORT_SLEEP = 64'hFFFF_FFFF_FFFF_FFFA;
  localparam logic [63:0] PORT_DRAW  = 64'hFFFF_FFFF_FFFF_FFF9;
  localparam logic [63:0] FREQ_VALUE = 64'h0000_0001_0000_0000;

  localparam logic [1:0] ST_RUNNING  = 2'd0;
  localparam logic [1:0] ST_COMPLETE = 2'd1;
  localparam logic [1:0] ST_MEMERR   = 2'd2;

  localparam logic [2:0] EV_NONE  = 3'd0;
  localparam logic [2:0] EV_EXIT  = 3'd1;
  localparam logic [2:0] EV_PRINT = 3'd2;
  localparam logic [2:0] EV_SLEEP = 3'd3;
  localparam logic [2:0] EV_DRAW  = 3'd4;

  localparam logic [1:0] MODE_WRITE  = 2'd0;
  localparam logic [1:0] MODE_SET_IP = 2'd1;
  localparam logic [1:0] MODE_EXEC   = 2'd2;
  localparam logic [1:0] MODE_READ   = 2'd3;

  // Address sources for the single memory port.
  localparam logic [1:0] ADDR_PTR   = 2'd0;
  localparam logic [1:0] ADDR_A     = 2'd1;
  localparam logic [1:0] ADDR_B     = 2'd2;
  localparam logic [1:0] ADDR_WADDR = 2'd3;

  // Register load targets for the word read in the previous step.
  localparam logic [2:0] LD_NONE = 3'd0;
  localparam logic [2:0] LD_A    = 3'd1;
  localparam logic [2:0] LD_B    = 3'd2;
  localparam logic [2:0] LD_C    = 3'd3;
  localparam logic [2:0] LD_MB   = 3'd4;

  // Architectural operations of a step.
  localparam logic [2:0] OP_NONE     = 3'd0;
  localparam logic [2:0] OP_SET_IP   = 3'd1;
  localparam logic [2:0] OP_EXEC_END = 3'd2;
  localparam logic [2:0] OP_WRITE    = 3'd3;
  localparam logic [2:0] OP_READ_END = 3'd4;

  localparam int STEP_W = 4;

  // Microprogram entry points and steps.
  localparam logic [STEP_W-1:0] STEP_FETCH_A  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_FETCH_B  = 4'd1;
  localparam logic [STEP_W-1:0] STEP_FETCH_C  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_READ_MB  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_READ_MA  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_EXEC_END = 4'd5;
  localparam logic [STEP_W-1:0] STEP_WRITE    = 4'd6;
  localparam logic [STEP_W-1:0] STEP_SET_IP   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_READ     = 4'd8;
  localparam logic [STEP_W-1:0] STEP_READ_END = 4'd9;

  typedef struct packed {
    logic [1:0] addr_sel;
    logic       rd;
    logic [2:0] ld;
    logic       ptr_inc;
    logic [2:0] op;
    logic       halt_chk;
    logic       last;
  } ctrl_word_t;

  typedef struct packed {
    ctrl_word_t cw;
    logic       busy;
    logic       go;
    logic       finish;
  } seq_ctl_t;

  typedef struct packed {
    logic [63:0] next_ip;
    logic [1:0]  run_state;
    logic [2:0]  event_kind;
    logic [63:0] event_value;
    logic [63:0] read_data;
  } result_t;

  // Control store. Each read issued in a step is consumed by the next step, by its load or its operation.
  function automatic ctrl_word_t micro_rom(input logic [STEP_W-1:0] step);
    ctrl_word_t cw;
    cw = '{addr_sel: ADDR_PTR, rd: 1'b0, ld: LD_NONE, ptr_inc: 1'b0,
           op: OP_NONE, halt_chk: 1'b0, last: 1'b1};
    case (step)
      STEP_FETCH_A: begin
        cw.addr_sel = ADDR_PTR; cw.rd = 1'b1; cw.ptr_inc = 1'b1;
        cw.halt_chk = 1'b1; cw.last = 1'b0;
      end
      STEP_FETCH_B: begin
        cw.addr_sel = ADDR_PTR; cw.rd = 1'b1; cw.ptr_inc = 1'b1;
        cw.ld = LD_A; cw.last = 1'b0;
      end
      STEP_FETCH_C: begin
        cw.addr_sel = ADDR_PTR; cw.rd = 1'b1; cw.ptr_inc = 1'b1;
        cw.ld = LD_B; cw.last = 1'b0;
      end
      STEP_READ_MB: begin
        cw.addr_sel = ADDR_B; cw.rd = 1'b1; cw.ld = LD_C; cw.last = 1'b0;
      end
      STEP_READ_MA: begin
        cw.addr_sel = ADDR_A; cw.rd = 1'b1; cw.ld = LD_MB; cw.last = 1'b0;
      end
      STEP_EXEC_END: begin
        cw.addr_sel = ADDR_A; cw.op = OP_EXEC_END;
      end
      STEP_WRITE: begin
        cw.addr_sel = ADDR_WADDR; cw.op = OP_WRITE;
      end
      STEP_SET_IP: begin
        cw.op = OP_SET_IP;
      end
      STEP_READ: begin
        cw.addr_sel = ADDR_WADDR; cw.rd = 1'b1; cw.last = 1'b0;
      end
      STEP_READ_END: begin
        cw.op = OP_READ_END;
      end
      default: begin
        cw.last = 1'b1;
      end
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

>>> rtl/sboic_ram.sv
// Single-port word memory with a registered read.
`default_nettype none

module sboic_ram #(
  parameter int MEM_DEPTH = 65536,
  parameter int AW        = 16
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [63:0]   wdata,
  output logic [63:0]        rdata
);

  logic [63:0] mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/sboic_seq.sv
// Microcode sequencer: step counter, control store lookup and completion control.
`default_nettype none

module sboic_seq (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [1:0]       mode,
  input  wire logic             running,
  input  wire logic             out_stall,
  output sboic_pkg::seq_ctl_t   ctl
);
  import sboic_pkg::*;

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] entry;
  ctrl_word_t        cw;
  logic              end_now;
  logic              go;

  always_comb begin
    case (mode)
      MODE_WRITE:  entry = STEP_WRITE;
      MODE_SET_IP: entry = STEP_SET_IP;
      MODE_EXEC:   entry = STEP_FETCH_A;
      MODE_READ:   entry = STEP_READ;
      default:     entry = STEP_READ;
    endcase
  end

  assign cw      = micro_rom(step);
  // A step that ends the program jumps out early when the machine is stopped.
  assign end_now = cw.last || (cw.halt_chk && !running);
  // The last step waits until the result register has room.
  assign go      = busy && !(end_now && out_stall);

  assign ctl.cw     = cw;
  assign ctl.busy   = busy;
  assign ctl.go     = go;
  assign ctl.finish = go && end_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= STEP_FETCH_A;
    end else if (start) begin
      busy <= 1'b1;
      step <= entry;
    end else if (go) begin
      if (end_now) begin
        busy <= 1'b0;
      end else begin
        step <= step + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/sboic_dp.sv
// Datapath: operand registers, subtractor, port decode, memory port and clearing pass.
`default_nettype none

module sboic_dp #(
  parameter int MEM_DEPTH = 65536
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [15:0]      word_address,
  input  wire logic [63:0]      word_value,
  input  wire logic [7:0]       stdin_byte,
  input  wire logic [63:0]      time_now,
  input  wire sboic_pkg::seq_ctl_t ctl,
  output logic                  running,
  output logic                  clearing,
  output sboic_pkg::result_t    res
);
  import sboic_pkg::*;

  localparam int          AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam logic [63:0] DEPTH64   = 64'(MEM_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_DEPTH - 1);

  // Item operands, held for the whole program.
  logic [15:0] waddr;
  logic [63:0] wval;
  logic [7:0]  sbyte;
  logic [63:0] tnow;

  logic [63:0] ptr;
  logic [63:0] reg_a;
  logic [63:0] reg_b;
  logic [63:0] reg_c;
  logic [63:0] mb;
  logic [63:0] pc;
  logic [1:0]  status;
  logic        rd_ok;
  logic [AW-1:0] clr_cnt;

  logic [63:0] sel_addr;
  logic        addr_ok;
  logic        do_rd;
  logic        do_wr;
  logic [63:0] ram_q;
  logic [63:0] rd_word;
  logic [63:0] diff;
  logic [63:0] mb_next;
  logic        ram_en;
  logic        ram_we;
  logic [AW-1:0] ram_addr;
  logic [63:0] ram_wdata;
  logic [63:0] pc_next;
  logic [1:0]  status_next;
  logic [2:0]  ev;
  logic [63:0] ev_val;

  always_comb begin
    case (ctl.cw.addr_sel)
      ADDR_PTR:   sel_addr = ptr;
      ADDR_A:     sel_addr = reg_a;
      ADDR_B:     sel_addr = reg_b;
      ADDR_WADDR: sel_addr = {48'd0, waddr};
      default:    sel_addr = ptr;
    endcase
  end

  assign addr_ok = sel_addr < DEPTH64;
  assign do_rd   = ctl.go && ctl.cw.rd && addr_ok;
  assign do_wr   = ctl.go && addr_ok &&
                   (ctl.cw.op == OP_EXEC_END || ctl.cw.op == OP_WRITE);
  // Reads outside the memory return zero.
  assign rd_word = rd_ok ? ram_q : 64'd0;
  assign diff    = rd_word - mb;
  assign running = status == ST_RUNNING;

  assign ram_en    = clearing || do_rd || do_wr;
  assign ram_we    = clearing || do_wr;
  assign ram_addr  = clearing ? clr_cnt : sel_addr[AW-1:0];
  assign ram_wdata = clearing ? 64'd0 : ((ctl.cw.op == OP_WRITE) ? wval : diff);

  sboic_ram #(
    .MEM_DEPTH (MEM_DEPTH),
    .AW        (AW)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_q)
  );

  always_comb begin
    if (reg_b < DEPTH64) begin
      mb_next = rd_word;
    end else if (reg_b == PORT_STDIN) begin
      mb_next = {56'd0, sbyte};
    end else if (reg_b == PORT_FREQ) begin
      mb_next = FREQ_VALUE;
    end else if (reg_b == PORT_TIME) begin
      mb_next = tnow;
    end else begin
      mb_next = 64'd0;
    end
  end

  always_comb begin
    pc_next     = pc;
    status_next = status;
    ev          = EV_NONE;
    ev_val      = 64'd0;
    case (ctl.cw.op)
      OP_SET_IP: begin
        pc_next = wval;
      end
      OP_WRITE: begin
        if (!addr_ok && wval != 64'd0) begin
          status_next = ST_MEMERR;
        end
      end
      OP_EXEC_END: begin
        if (reg_a < DEPTH64) begin
          pc_next = (rd_word <= mb) ? reg_c : ptr;
        end else begin
          pc_next = reg_c;
          if (reg_a < PORT_BASE) begin
            // Storing the nonzero value 0 - mb outside the memory is an error.
            if (mb != 64'd0) begin
              status_next = ST_MEMERR;
            end
          end else if (reg_a == PORT_EXIT) begin
            status_next = ST_COMPLETE;
            ev          = EV_EXIT;
          end else if (reg_a == PORT_PRINT) begin
            ev     = EV_PRINT;
            ev_val = mb;
          end else if (reg_a == PORT_SLEEP) begin
            ev     = EV_SLEEP;
            ev_val = mb;
          end else if (reg_a == PORT_DRAW) begin
            ev     = EV_DRAW;
            ev_val = mb;
          end
        end
      end
      default: begin
        pc_next = pc;
      end
    endcase
  end

  assign res.next_ip     = pc_next;
  assign res.run_state   = status_next;
  assign res.event_kind  = ev;
  assign res.event_value = ev_val;
  assign res.read_data   = (ctl.cw.op == OP_READ_END) ? rd_word : 64'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= 64'd0;
      status   <= ST_RUNNING;
      rd_ok    <= 1'b0;
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else begin
      if (clearing) begin
        if (clr_cnt == LAST_ADDR) begin
          clearing <= 1'b0;
        end else begin
          clr_cnt <= clr_cnt + 1'b1;
        end
      end
      if (ctl.go) begin
        rd_ok  <= do_rd;
        pc     <= pc_next;
        status <= status_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      waddr <= word_address;
      wval  <= word_value;
      sbyte <= stdin_byte;
      tnow  <= time_now;
      ptr   <= pc;
    end else if (ctl.go) begin
      if (ctl.cw.ptr_inc) begin
        ptr <= ptr + 64'd1;
      end
      case (ctl.cw.ld)
        LD_A:    reg_a <= rd_word;
        LD_B:    reg_b <= rd_word;
        LD_C:    reg_c <= rd_word;
        LD_MB:   mb    <= mb_next;
        default: reg_a <= reg_a;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/subtract_branch_one_instruction_cpu_unit.sv
// Top level of the 64-bit subtract-and-branch one-instruction CPU.
`default_nettype none

// A 64-bit one-instruction computer: every instruction at IP reads A, B and C,
// subtracts mem[B] from mem[A], writes the difference back to mem[A] and jumps
// to C when mem[A] <= mem[B]. Each input beat carries one command (write a word,
// set IP, execute one instruction, read a word) and yields exactly one result
// beat with the new IP, the machine status, an optional port event and the read
// word. Addresses at or above 2^63 are ports: B may read the input byte, the
// frequency 2^32 or the supplied time, and A may signal exit, print, sleep or
// draw. After reset the memory is cleared one word per cycle, and s_tready stays
// low until that clearing pass is over. All memory traffic goes through one
// single-port RAM, and a control store steps the datapath through it: an execute
// beat runs three operand fetches, the two data reads and the write back, a read
// beat a read and its return, and a write or set-IP beat just its write or IP
// update. A new beat is not taken while one is in progress; s_tready rises again
// in the cycle after the result is latched. A result waiting in the output
// register does not stop the next beat from being accepted; only the final step
// of that beat waits for room.
module subtract_branch_one_instruction_cpu_unit #(
  parameter int MEM_DEPTH = sboic_pkg::DEF_MEM_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // word_address[15:0], word_value[79:16], stdin_byte[87:80], time_now[151:88]
  input  wire logic [151:0] s_tdata,
  // mode[1:0]
  input  wire logic [1:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // next_ip[63:0], run_state[65:64], event_value[129:66], read_data[193:130],
  // zero fill[199:194]
  output logic [199:0]      m_tdata,
  // event_kind[2:0]
  output logic [2:0]        m_tuser
);
  import sboic_pkg::*;

  seq_ctl_t ctl;
  result_t  res;
  result_t  out_res;
  logic     running;
  logic     clearing;
  logic     start;

  // New commands enter only when the sequencer is free and memory is cleared.
  assign s_tready = !ctl.busy && !clearing;
  assign start    = s_tvalid && s_tready;

  sboic_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .mode      (s_tuser),
    .running   (running),
    .out_stall (m_tvalid && !m_tready),
    .ctl       (ctl)
  );

  sboic_dp #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .word_address (s_tdata[15:0]),
    .word_value   (s_tdata[79:16]),
    .stdin_byte   (s_tdata[87:80]),
    .time_now     (s_tdata[151:88]),
    .ctl          (ctl),
    .running      (running),
    .clearing     (clearing),
    .res          (res)
  );

  // Output register: loaded when a program finishes, emptied by the consumer.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      out_res <= res;
    end
  end

  assign m_tdata = {6'd0, out_res.read_data, out_res.event_value,
                    out_res.run_state, out_res.next_ip};
  assign m_tuser = out_res.event_kind;

`ifndef NO_ASSERTIONS
  // A finishing program must never overwrite a result that has not been taken.
  a_finish_room: assert property (@(posedge clk) disable iff (rst)
    ctl.finish |-> (!m_tvalid || m_tready))
    else $error("result register overwritten");

  // An accepted beat always starts a program.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> ctl.busy)
    else $error("accepted beat did not start the sequencer");

  // No beat is taken while the memory is still being cleared.
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready)
    else $error("beat accepted during clearing pass");

  // An exit event always reports the completed state.
  a_exit_status: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == EV_EXIT) |-> (m_tdata[65:64] == ST_COMPLETE))
    else $error("exit event without completed status");
`endif

endmodule

`default_nettype wire
